/* hdl/pfs_pkg.sv */
// Package for the pancake flip sequence block: field widths, default stack
// depth and the shared start and result structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfs_pkg;

  localparam int PANCAKE_W = 5;
  localparam int FLIP_W    = 5;
  localparam int MAX_N_DEF = 16;

  // Start request from the loader to the sequencer
  typedef struct packed {
    logic go;
    logic ok;
  } pfs_start_t;

  // One result of the flip sequence
  typedef struct packed {
    logic [FLIP_W-1:0] flip_size;
    logic              error;
    logic              last_out;
  } pfs_res_t;

endpackage

`default_nettype wire

/* hdl/pfs_if.sv */
// Valid/ready channel interfaces for the stack input and the flip results.
// Depends on pfs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfs_in_if;
  logic                           valid;
  logic                           ready;
  logic [pfs_pkg::PANCAKE_W-1:0]  pancake;
  logic                           last_in;

  modport source (output valid, output pancake, output last_in, input ready);
  modport sink   (input valid, input pancake, input last_in, output ready);
endinterface

interface pfs_out_if;
  logic                         valid;
  logic                         ready;
  logic [pfs_pkg::FLIP_W-1:0]   flip_size;
  logic                         error;
  logic                         last_out;

  modport source (output valid, output flip_size, output error, output last_out, input ready);
  modport sink   (input valid, input flip_size, input error, input last_out, output ready);
endinterface

`default_nettype wire

/* hdl/pfs_ram.sv */
// Stack store: one write port, two registered read ports with a shared
// read enable. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pfs_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_a,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* hdl/pfs_ctrl.sv */
// Flip sequencer: searches the stack store for each size, emits flips and
// reverses the stack in place through the RAM ports. Depends on pfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfs_ctrl #(
  parameter int MAX_N = pfs_pkg::MAX_N_DEF,
  parameter int IDX_W = $clog2(MAX_N),
  parameter int CNT_W = $clog2(MAX_N + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pfs_pkg::pfs_start_t           start,
  input  wire logic [CNT_W-1:0]              n,
  output logic                               idle,
  output logic                               ram_re,
  output logic [IDX_W-1:0]                   ram_raddr_a,
  output logic [IDX_W-1:0]                   ram_raddr_b,
  input  wire logic [pfs_pkg::PANCAKE_W-1:0] ram_rdata_a,
  input  wire logic [pfs_pkg::PANCAKE_W-1:0] ram_rdata_b,
  output logic                               ram_we,
  output logic [IDX_W-1:0]                   ram_waddr,
  output logic [pfs_pkg::PANCAKE_W-1:0]      ram_wdata,
  output logic                               res_valid,
  output pfs_pkg::pfs_res_t                  res,
  input  wire logic                          res_ready
);
  import pfs_pkg::*;

  localparam int CMP_W = (CNT_W > PANCAKE_W) ? CNT_W : PANCAKE_W;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_FIND_RD  = 8'b0000_0010,
    ST_FIND_CMP = 8'b0000_0100,
    ST_PUSH     = 8'b0000_1000,
    ST_REV_RD   = 8'b0001_0000,
    ST_REV_WA   = 8'b0010_0000,
    ST_REV_WB   = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } pfs_state_t;

  pfs_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] s_r, s_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] flip_k_r, flip_k_nxt;
  logic [CNT_W-1:0] hold_k_r, hold_k_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic             phase_r, phase_nxt;
  logic             err_r, err_nxt;
  logic             match;
  logic [CNT_W-1:0] scan_p1;

  assign match   = (CMP_W'(ram_rdata_a) == CMP_W'(s_r));
  assign scan_p1 = CNT_W'(scan_r) + CNT_W'(1);
  assign idle    = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    s_nxt       = s_r;
    scan_nxt    = scan_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    flip_k_nxt  = flip_k_r;
    hold_k_nxt  = hold_k_r;
    hold_v_nxt  = hold_v_r;
    phase_nxt   = phase_r;
    err_nxt     = err_r;
    ram_re      = 1'b0;
    ram_raddr_a = scan_r;
    ram_raddr_b = hi_r;
    ram_we      = 1'b0;
    ram_waddr   = lo_r;
    ram_wdata   = ram_rdata_b;
    res_valid   = 1'b0;
    res         = '{flip_size: FLIP_W'(hold_k_r), error: 1'b0, last_out: 1'b0};

    unique case (state_r)
      ST_IDLE: begin
        if (start.go) begin
          n_nxt = n;
          if (!start.ok) begin
            err_nxt   = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            err_nxt    = 1'b0;
            hold_v_nxt = 1'b0;
            s_nxt      = n;
            scan_nxt   = '0;
            state_nxt  = ST_FIND_RD;
          end
        end
      end
      ST_FIND_RD: begin
        ram_re      = 1'b1;
        ram_raddr_a = scan_r;
        state_nxt   = ST_FIND_CMP;
      end
      ST_FIND_CMP: begin
        if (!match) begin
          scan_nxt  = scan_r + IDX_W'(1);
          state_nxt = ST_FIND_RD;
        end else if (scan_p1 == s_r) begin
          // Already in place: move to the next smaller size
          if (s_r == CNT_W'(2)) begin
            state_nxt = ST_FINISH;
          end else begin
            s_nxt     = s_r - CNT_W'(1);
            scan_nxt  = '0;
            state_nxt = ST_FIND_RD;
          end
        end else if (scan_r != '0) begin
          flip_k_nxt = scan_p1;
          phase_nxt  = 1'b1;
          state_nxt  = ST_PUSH;
        end else begin
          flip_k_nxt = s_r;
          phase_nxt  = 1'b0;
          state_nxt  = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // Release the held flip, now known not to be last, and hold the new one
        res_valid = hold_v_r;
        if (!hold_v_r || res_ready) begin
          hold_v_nxt = 1'b1;
          hold_k_nxt = flip_k_r;
          lo_nxt     = '0;
          hi_nxt     = IDX_W'(flip_k_r - CNT_W'(1));
          state_nxt  = ST_REV_RD;
        end
      end
      ST_REV_RD: begin
        if (lo_r < hi_r) begin
          ram_re      = 1'b1;
          ram_raddr_a = lo_r;
          ram_raddr_b = hi_r;
          state_nxt   = ST_REV_WA;
        end else if (phase_r) begin
          flip_k_nxt = s_r;
          phase_nxt  = 1'b0;
          state_nxt  = ST_PUSH;
        end else if (s_r == CNT_W'(2)) begin
          state_nxt = ST_FINISH;
        end else begin
          s_nxt     = s_r - CNT_W'(1);
          scan_nxt  = '0;
          state_nxt = ST_FIND_RD;
        end
      end
      ST_REV_WA: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = ram_rdata_b;
        state_nxt = ST_REV_WB;
      end
      ST_REV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = ram_rdata_a;
        lo_nxt    = lo_r + IDX_W'(1);
        hi_nxt    = hi_r - IDX_W'(1);
        state_nxt = ST_REV_RD;
      end
      ST_FINISH: begin
        res_valid = 1'b1;
        if (err_r) begin
          res = '{flip_size: '0, error: 1'b1, last_out: 1'b1};
        end else if (hold_v_r) begin
          res = '{flip_size: FLIP_W'(hold_k_r), error: 1'b0, last_out: 1'b1};
        end else begin
          res = '{flip_size: '0, error: 1'b0, last_out: 1'b1};
        end
        if (res_ready) begin
          hold_v_nxt = 1'b0;
          err_nxt    = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hold_v_r <= 1'b0;
      phase_r  <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hold_v_r <= hold_v_nxt;
      phase_r  <= phase_nxt;
      err_r    <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    s_r      <= s_nxt;
    scan_r   <= scan_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    flip_k_r <= flip_k_nxt;
    hold_k_r <= hold_k_nxt;
  end

  // Swap pair stays ordered
  a_rev_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REV_WA) |-> (lo_r < hi_r))
    else $error("reversal pair out of order");

  // Search never leaves the loaded stack
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND_CMP) |-> (CNT_W'(scan_r) < n_r))
    else $error("search ran past the stack");

  // Every flip covers at least two pancakes and never more than the current size
  a_flip_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) |-> ((flip_k_r >= CNT_W'(2)) && (flip_k_r <= s_r)))
    else $error("flip length out of range");

endmodule

`default_nettype wire

/* hdl/pancake_flip_sequence_core.sv */
// Pancake-sort flip planner top level: loads a stack, checks it, emits flips.
// Loading takes one item per cycle while the sequencer is idle; after the
// bottom item, the sequencer starts, searches the store slot by slot for each
// size, reverses each flip in place with two writes per swapped pair on the
// single RAM write port, and then finishes. Input is not ready until the final
// result is in the output register. Reset (rst_n, synchronous, active low) clears control state; store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module pancake_flip_sequence_core #(
  parameter int MAX_N = pfs_pkg::MAX_N_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pfs_in_if.sink    in_ch,
  pfs_out_if.source out_ch
);
  import pfs_pkg::*;

  localparam int IDX_W = $clog2(MAX_N);
  localparam int CNT_W = $clog2(MAX_N + 1);

  // Loader state for the stack being received
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [MAX_N-1:0] seen_r, seen_nxt;
  logic             bad_r, bad_nxt;
  logic             pend_r, pend_nxt;

  logic             in_fire;
  logic             room;
  logic             v_bad;
  logic [IDX_W-1:0] v_idx;
  logic [MAX_N-1:0] want;

  pfs_start_t       start;
  logic             ctrl_idle;

  // RAM port signals
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [PANCAKE_W-1:0] ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr_a;
  logic [IDX_W-1:0]     ram_raddr_b;
  logic [PANCAKE_W-1:0] ram_rdata_a;
  logic [PANCAKE_W-1:0] ram_rdata_b;
  logic                 ctrl_we;
  logic [IDX_W-1:0]     ctrl_waddr;
  logic [PANCAKE_W-1:0] ctrl_wdata;

  // Result path and output register
  logic      res_valid;
  pfs_res_t  res;
  logic      res_ready;
  logic      out_valid_r, out_valid_nxt;
  pfs_res_t  out_res_r, out_res_nxt;

  // Accept items only while the sequencer is idle and no stack waits to start
  assign in_ch.ready = ctrl_idle && !pend_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign room  = (len_r < CNT_W'(MAX_N));
  assign v_bad = (in_ch.pancake == '0) ||
                 ({1'b0, in_ch.pancake} > (PANCAKE_W + 1)'(MAX_N));
  assign v_idx = IDX_W'(in_ch.pancake - PANCAKE_W'(1));

  always_comb begin
    len_nxt  = len_r;
    seen_nxt = seen_r;
    bad_nxt  = bad_r;
    pend_nxt = pend_r;
    if (start.go) begin
      // Sequencer takes the stack: drop loader state for the next one
      len_nxt  = '0;
      seen_nxt = '0;
      bad_nxt  = 1'b0;
      pend_nxt = 1'b0;
    end else if (in_fire) begin
      if (!room) begin
        bad_nxt = 1'b1;
      end else begin
        if (v_bad) begin
          bad_nxt = 1'b1;
        end else begin
          if (seen_r[v_idx]) begin
            bad_nxt = 1'b1;
          end
          seen_nxt[v_idx] = 1'b1;
        end
        len_nxt = len_r + CNT_W'(1);
      end
      pend_nxt = in_ch.last_in;
    end
  end

  // Sizes 1..n must each appear exactly once
  always_comb begin
    for (int j = 0; j < MAX_N; j++) begin
      want[j] = (CNT_W'(j) < len_r);
    end
  end

  assign start.go = pend_r;
  assign start.ok = !bad_r && (len_r >= CNT_W'(2)) && (seen_r == want);

  // Loader writes while receiving; the sequencer writes only while sorting
  assign ram_we    = (in_fire && room) || ctrl_we;
  assign ram_waddr = in_fire ? len_r[IDX_W-1:0] : ctrl_waddr;
  assign ram_wdata = in_fire ? in_ch.pancake : ctrl_wdata;

  pfs_ram #(
    .DEPTH (MAX_N),
    .AW    (IDX_W),
    .DW    (PANCAKE_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  pfs_ctrl #(
    .MAX_N (MAX_N),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .n           (len_r),
    .idle        (ctrl_idle),
    .ram_re      (ram_re),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b),
    .ram_we      (ctrl_we),
    .ram_waddr   (ctrl_waddr),
    .ram_wdata   (ctrl_wdata),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  // Output register: load a new result when empty or when the current
  // transfer completes in the same cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.flip_size = out_res_r.flip_size;
  assign out_ch.error     = out_res_r.error;
  assign out_ch.last_out  = out_res_r.last_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      seen_r      <= '0;
      bad_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      seen_r      <= seen_nxt;
      bad_r       <= bad_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  // An error result is always a single, final result with no flip
  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error) |-> (out_ch.last_out && (out_ch.flip_size == '0)))
    else $error("error result not final");

  // A waiting stack is handed to the sequencer while pend_r is set, which clears it
  a_pend_once: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> !pend_r)
    else $error("stack start not taken");

  // An accepted item leaves a non-empty stack or closes it
  a_load_track: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (pend_r || (len_r != '0)))
    else $error("accepted item lost");

endmodule

`default_nettype wire
